### rtl/atss_pkg.sv
package atss_pkg;

    // result format: unsigned Q0.16 with room for exactly 1.0
    localparam int TS_W = 17;
    localparam logic [TS_W-1:0] ONE_Q16 = 17'h10000;

    // commands from the sequencer to the datapath
    typedef struct packed {
        logic acc;        // fold the accepted particle into the frame extremes
        logic load;       // latch ranges and peaks, clear extremes and sum
        logic sq_load;    // take next operand into the shift-add multiplier
        logic sq_step;    // one multiplier bit
        logic rt_load;    // start square root on the sum of squares
        logic rt_step;    // one root bit
        logic dv_load;    // start reciprocal division
        logic dv_step;    // one quotient bit
        logic vec_end;    // candidate step ready, clear sum
        logic first_vec;  // with vec_end: candidate belongs to velocity
        logic out_load;   // copy chosen step into output register
    } t_cmd;

endpackage

### rtl/atss_dp.sv
module atss_dp #(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  atss_pkg::t_cmd                i_cmd,
    input  logic signed [VALUE_WIDTH-1:0] i_vel_x,
    input  logic signed [VALUE_WIDTH-1:0] i_vel_y,
    input  logic signed [VALUE_WIDTH-1:0] i_vel_z,
    input  logic signed [VALUE_WIDTH-1:0] i_force_x,
    input  logic signed [VALUE_WIDTH-1:0] i_force_y,
    input  logic signed [VALUE_WIDTH-1:0] i_force_z,
    output logic [atss_pkg::TS_W-1:0]     o_time_step
);
    import atss_pkg::*;

    localparam int W     = VALUE_WIDTH;
    localparam int SUM_W = 2 * W + 2;
    localparam int ROOT_W = W + 1;
    localparam int RREM_W = W + 3;
    localparam int DVD_W = 17 + FRAC_BITS;
    localparam logic [ROOT_W-1:0] UNIT = ROOT_W'(1) << FRAC_BITS;

    logic signed [W-1:0] w_vel [3];
    logic signed [W-1:0] w_frc [3];
    logic [W-1:0]        w_fmag [3];

    logic signed [W-1:0] r_v_hi [3];
    logic signed [W-1:0] r_v_lo [3];
    logic [W-1:0]        r_f_pk [3];
    logic [W-1:0]        r_opd [6];

    logic [2*W-1:0]      r_mcand;
    logic [W-1:0]        r_mplier;
    logic [SUM_W-1:0]    r_sum;

    logic [SUM_W-1:0]    r_rad;
    logic [RREM_W-1:0]   r_rrem;
    logic [ROOT_W-1:0]   r_root;
    logic [RREM_W+1:0]   w_rt_rem;
    logic [RREM_W+1:0]   w_rt_trial;

    logic [DVD_W-1:0]    r_dvd;
    logic [ROOT_W-1:0]   r_drem;
    logic [TS_W-1:0]     r_quo;
    logic [ROOT_W:0]     w_dv_rem;

    logic [TS_W-1:0]     w_cand;
    logic [TS_W-1:0]     r_tv;
    logic [TS_W-1:0]     r_tmin;
    logic [TS_W-1:0]     r_time_step;

    assign w_vel[0] = i_vel_x;
    assign w_vel[1] = i_vel_y;
    assign w_vel[2] = i_vel_z;
    assign w_frc[0] = i_force_x;
    assign w_frc[1] = i_force_y;
    assign w_frc[2] = i_force_z;

    // most negative value maps to 2^(W-1), exact as unsigned
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_fmag[k] = w_frc[k][W-1] ? $unsigned(-w_frc[k]) : $unsigned(w_frc[k]);
        end
    end

    // frame extremes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load) begin
            for (int k = 0; k < 3; k++) begin
                r_v_hi[k] <= '0;
                r_v_lo[k] <= '0;
                r_f_pk[k] <= '0;
            end
        end else if (i_cmd.acc) begin
            for (int k = 0; k < 3; k++) begin
                if (w_vel[k] > r_v_hi[k]) r_v_hi[k] <= w_vel[k];
                if (w_vel[k] < r_v_lo[k]) r_v_lo[k] <= w_vel[k];
                if (w_fmag[k] > r_f_pk[k]) r_f_pk[k] <= w_fmag[k];
            end
        end
    end

    // operand queue: three velocity ranges then three force peaks
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int k = 0; k < 3; k++) begin
                r_opd[k]     <= $unsigned(r_v_hi[k] - r_v_lo[k]);
                r_opd[k + 3] <= r_f_pk[k];
            end
        end else if (i_cmd.sq_load) begin
            for (int k = 0; k < 5; k++) begin
                r_opd[k] <= r_opd[k + 1];
            end
            r_opd[5] <= '0;
        end
    end

    // shift-add squaring into the exact sum
    always_ff @(posedge i_clk) begin
        if (i_cmd.load || i_cmd.vec_end) begin
            r_sum <= '0;
        end else if (i_cmd.sq_step && r_mplier[0]) begin
            r_sum <= r_sum + SUM_W'(r_mcand);
        end
        if (i_cmd.sq_load) begin
            r_mcand  <= (2*W)'(r_opd[0]);
            r_mplier <= r_opd[0];
        end else if (i_cmd.sq_step) begin
            r_mcand  <= r_mcand << 1;
            r_mplier <= r_mplier >> 1;
        end
    end

    // restoring square root, two radicand bits per step
    assign w_rt_rem   = {r_rrem, r_rad[SUM_W-1 -: 2]};
    assign w_rt_trial = (RREM_W + 2)'({r_root, 2'b01});

    always_ff @(posedge i_clk) begin
        if (i_cmd.rt_load) begin
            r_rad  <= r_sum;
            r_rrem <= '0;
            r_root <= '0;
        end else if (i_cmd.rt_step) begin
            r_rad <= r_rad << 2;
            if (w_rt_rem >= w_rt_trial) begin
                r_rrem <= RREM_W'(w_rt_rem - w_rt_trial);
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rrem <= RREM_W'(w_rt_rem);
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    // restoring division of 2^(16+FRAC_BITS) by the root
    assign w_dv_rem = {r_drem, r_dvd[DVD_W-1]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.dv_load) begin
            r_dvd  <= DVD_W'(1) << (DVD_W - 1);
            r_drem <= '0;
            r_quo  <= '0;
        end else if (i_cmd.dv_step) begin
            r_dvd <= r_dvd << 1;
            if (w_dv_rem >= {1'b0, r_root}) begin
                r_drem <= ROOT_W'(w_dv_rem - {1'b0, r_root});
                r_quo  <= {r_quo[TS_W-2:0], 1'b1};
            end else begin
                r_drem <= w_dv_rem[ROOT_W-1:0];
                r_quo  <= {r_quo[TS_W-2:0], 1'b0};
            end
        end
    end

    // a norm below one (zero too) limits the step to 1.0
    assign w_cand = (r_root < UNIT) ? ONE_Q16 : r_quo;

    always_ff @(posedge i_clk) begin
        if (i_cmd.vec_end) begin
            if (i_cmd.first_vec) begin
                r_tv <= w_cand;
            end else begin
                r_tmin <= (w_cand < r_tv) ? w_cand : r_tv;
            end
        end
        if (i_cmd.out_load) begin
            r_time_step <= r_tmin;
        end
    end

    assign o_time_step = r_time_step;

    a_cand_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.vec_end |-> w_cand <= ONE_Q16)
        else $error("candidate step above 1.0");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_cmd.dv_step) && r_root != '0) |-> r_drem < r_root)
        else $error("division remainder not below divisor");

endmodule

### rtl/atss_ctrl.sv
module atss_ctrl #(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_last,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output atss_pkg::t_cmd o_cmd
);
    import atss_pkg::*;

    localparam int CNT_MAX = (VALUE_WIDTH > 16 + FRAC_BITS) ? VALUE_WIDTH : 16 + FRAC_BITS;
    localparam int CW      = $clog2(CNT_MAX + 1);
    localparam logic [CW-1:0] SQ_LAST = CW'(VALUE_WIDTH - 1);
    localparam logic [CW-1:0] RT_LAST = CW'(VALUE_WIDTH);
    localparam logic [CW-1:0] DV_LAST = CW'(16 + FRAC_BITS);
    localparam logic [1:0]    AXIS_LAST = 2'd2;

    typedef enum logic [9:0] {
        S_ACC     = 10'b0000000001,
        S_LOAD    = 10'b0000000010,
        S_SQ_LD   = 10'b0000000100,
        S_SQ      = 10'b0000001000,
        S_RT_LD   = 10'b0000010000,
        S_RT      = 10'b0000100000,
        S_DV_LD   = 10'b0001000000,
        S_DV      = 10'b0010000000,
        S_VEC_END = 10'b0100000000,
        S_OUT     = 10'b1000000000
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [1:0]    r_axis, n_axis;
    logic          r_vec, n_vec;
    logic          r_out_valid, n_out_valid;
    logic          w_in_acc;
    t_cmd          w_cmd;

    assign o_in_stall = (r_state != S_ACC);
    assign w_in_acc   = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_axis  = r_axis;
        n_vec   = r_vec;
        w_cmd   = '0;
        case (r_state)
            S_ACC: begin
                w_cmd.acc = w_in_acc;
                if (w_in_acc && i_last) n_state = S_LOAD;
            end
            S_LOAD: begin
                w_cmd.load = 1'b1;
                n_axis     = '0;
                n_vec      = 1'b0;
                n_state    = S_SQ_LD;
            end
            S_SQ_LD: begin
                w_cmd.sq_load = 1'b1;
                n_cnt         = '0;
                n_state       = S_SQ;
            end
            S_SQ: begin
                w_cmd.sq_step = 1'b1;
                n_cnt         = r_cnt + 1'b1;
                if (r_cnt == SQ_LAST) begin
                    if (r_axis == AXIS_LAST) begin
                        n_axis  = '0;
                        n_state = S_RT_LD;
                    end else begin
                        n_axis  = r_axis + 1'b1;
                        n_state = S_SQ_LD;
                    end
                end
            end
            S_RT_LD: begin
                w_cmd.rt_load = 1'b1;
                n_cnt         = '0;
                n_state       = S_RT;
            end
            S_RT: begin
                w_cmd.rt_step = 1'b1;
                n_cnt         = r_cnt + 1'b1;
                if (r_cnt == RT_LAST) n_state = S_DV_LD;
            end
            S_DV_LD: begin
                w_cmd.dv_load = 1'b1;
                n_cnt         = '0;
                n_state       = S_DV;
            end
            S_DV: begin
                w_cmd.dv_step = 1'b1;
                n_cnt         = r_cnt + 1'b1;
                if (r_cnt == DV_LAST) n_state = S_VEC_END;
            end
            S_VEC_END: begin
                w_cmd.vec_end   = 1'b1;
                w_cmd.first_vec = !r_vec;
                if (!r_vec) begin
                    n_vec   = 1'b1;
                    n_state = S_SQ_LD;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = S_ACC;
                end
            end
            default: begin
                n_state = S_ACC;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (w_cmd.out_load) n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ACC;
            r_cnt       <= '0;
            r_axis      <= '0;
            r_vec       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_axis      <= n_axis;
            r_vec       <= n_vec;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

    a_last_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_last) |=> r_state == S_LOAD)
        else $error("last particle did not start the step computation");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_OUT))
        else $error("result raised outside the output state");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_valid && i_out_stall) |=> r_state == S_OUT)
        else $error("pending result overwritten");

endmodule

### rtl/adaptive_time_step_select_core.sv
// after the transfer of the last particle the sequencer runs its load, squaring, root,
//   division and candidate states, then offers the result; later if the output is stalled
// throughput: one particle per cycle while accumulating; the input stalls until the result
//   is loaded, a span set by one shared shift-add squarer, bit-serial root and divider
// reset: synchronous, active low; clears the frame extremes, sequencer and output valid
module adaptive_time_step_select_core #(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // particle channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [VALUE_WIDTH-1:0] i_vel_x,
    input  logic signed [VALUE_WIDTH-1:0] i_vel_y,
    input  logic signed [VALUE_WIDTH-1:0] i_vel_z,
    input  logic signed [VALUE_WIDTH-1:0] i_force_x,
    input  logic signed [VALUE_WIDTH-1:0] i_force_y,
    input  logic signed [VALUE_WIDTH-1:0] i_force_z,
    input  logic                          i_last_particle,
    // time step channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [atss_pkg::TS_W-1:0]     o_time_step
);
    import atss_pkg::*;

    // sequencer to datapath commands
    t_cmd w_cmd;

    // sequencer: accepts particle transfers while accumulating; after the last
    // particle it runs, for velocity range then force peak, three squarings,
    // one root and one reciprocal, then places the smaller step in the output
    // register; particles of the next frame may arrive while that result waits
    atss_ctrl #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last      (i_last_particle),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd)
    );

    // datapath: per-axis extremes, exact sum of squares, floored root,
    // truncated reciprocal limited to 1.0, minimum of the two candidates
    atss_dp #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_vel_x     (i_vel_x),
        .i_vel_y     (i_vel_y),
        .i_vel_z     (i_vel_z),
        .i_force_x   (i_force_x),
        .i_force_y   (i_force_y),
        .i_force_z   (i_force_z),
        .o_time_step (o_time_step)
    );

endmodule
